FILE: sv/assert_macros.svh
// assert_macros.svh: assertion macros used by the checker file hap_checker.sv.
// Depends on nothing; each use opens a labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property on the rising clock edge, off while reset is low.
`define HAP_ASSERT(lbl, clk_sig, rstn_sig, prop, msg) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (prop)) \
        else $error(msg);

// Assert that an antecedent implies a consequent in the same cycle.
`define HAP_ASSERT_IMP(lbl, clk_sig, rstn_sig, ante, cons, msg) \
    `HAP_ASSERT(lbl, clk_sig, rstn_sig, (ante) |-> (cons), msg)

// Assert that an antecedent implies a consequent in the next cycle.
`define HAP_ASSERT_NXT(lbl, clk_sig, rstn_sig, ante, cons, msg) \
    `HAP_ASSERT(lbl, clk_sig, rstn_sig, (ante) |=> (cons), msg)

`endif

FILE: sv/hap_pkg.sv
// hap_pkg: widths, character codes, parse phases and the hex digit decoder
// for the hex argument parser. Depends on nothing.
package hap_pkg;

    localparam int CHAR_W  = 8;
    localparam int VALUE_W = 32;
    localparam int CFG_W   = 2;
    localparam int COUNT_W = 5;
    localparam int NIBBLE_W = 4;

    // Field count register codes and reset value
    localparam logic [CFG_W-1:0] FIELDS_ONE   = 2'd1;
    localparam logic [CFG_W-1:0] FIELDS_TWO   = 2'd2;
    localparam logic [CFG_W-1:0] FIELDS_RESET = FIELDS_TWO;

    // Length limits and counter saturation
    localparam logic [COUNT_W-1:0] LEN_MAX_ONE = 5'd10;
    localparam logic [COUNT_W-1:0] LEN_MAX_TWO = 5'd21;
    localparam logic [COUNT_W-1:0] COUNT_SAT   = 5'd22;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_X     = 8'h78;
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;

    typedef enum logic [2:0] {
        PH_ZERO_A = 3'd0,
        PH_X_A    = 3'd1,
        PH_DIGITS_A = 3'd2,
        PH_ZERO_B = 3'd3,
        PH_X_B    = 3'd4,
        PH_DIGITS_B = 3'd5
    } phase_t;

    // Decode a hex digit; anything else reads as zero
    function automatic logic [NIBBLE_W-1:0] hex_nibble(input logic [CHAR_W-1:0] c);
        logic [NIBBLE_W-1:0] n;
        n = '0;
        if (c inside {[8'h30:8'h39]})
        begin
            n = c[NIBBLE_W-1:0];
        end
        else if (c inside {[8'h41:8'h46], [8'h61:8'h66]})
        begin
            n = c[NIBBLE_W-1:0] + 4'd9;
        end
        return n;
    endfunction

endpackage

FILE: sv/hap_char_if.sv
// hap_char_if: valid/ready channel that carries one argument character.
// Depends on hap_pkg for the character width.
interface hap_char_if;
    import hap_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] ch;

    modport source (output valid, output ch, input ready);
    modport sink   (input valid, input ch, output ready);
endinterface

FILE: sv/hap_result_if.sv
// hap_result_if: valid/ready channel that carries one parse result.
// Depends on hap_pkg for the value width.
interface hap_result_if;
    import hap_pkg::*;

    logic               valid;
    logic               ready;
    logic               ok;
    logic [VALUE_W-1:0] first_value;
    logic [VALUE_W-1:0] second_value;

    modport source (output valid, output ok, output first_value, output second_value,
                    input ready);
    modport sink   (input valid, input ok, input first_value, input second_value,
                    output ready);
endinterface

FILE: sv/hex_argument_parser.sv
// hex_argument_parser: streaming parser for "0xH.." and "0xH../0xH.." strings.
// Depends on hap_pkg, hap_char_if and hap_result_if.
//
//   channel   | dir | word                                  | accepted when
//   chars     | in  | ch[7:0]                               | valid && ready
//   results   | out | ok, first_value[31:0], second_value   | valid && ready
//   cfg       | in  | cfg_wr_data[1:0] (field count)        | cfg_wr_en
//
// One character per cycle; a NUL loads the result register in the same cycle.
// The result register stalls input only while it holds an untaken result.
// Reset clears the parse state, empties the result register, field count = 2.
// A taken result frees the register in the cycle it is taken.
module hex_argument_parser (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [hap_pkg::CFG_W-1:0] cfg_wr_data,
    hap_char_if.sink                  chars,
    hap_result_if.source              results
);
    import hap_pkg::*;

    logic [CFG_W-1:0]   field_count_reg;
    logic [COUNT_W-1:0] char_count_reg, char_count_next;
    phase_t             phase_reg, phase_next;
    logic [VALUE_W-1:0] first_acc_reg, first_acc_next;
    logic [VALUE_W-1:0] second_acc_reg, second_acc_next;
    logic               format_bad_reg, format_bad_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_ok_reg, out_ok_next;
    logic [VALUE_W-1:0] out_first_reg, out_first_next;
    logic [VALUE_W-1:0] out_second_reg, out_second_next;

    logic               accept;
    logic               two_fields;
    logic               match_ok;
    logic [NIBBLE_W-1:0] nibble;

    // Accept while the result register is empty or being emptied
    assign chars.ready = !out_valid_reg || results.ready;
    assign accept      = chars.valid && chars.ready;
    assign two_fields  = (field_count_reg != FIELDS_ONE);
    assign nibble      = hex_nibble(chars.ch);

    // Check format, phase and length at the terminator
    always_comb
    begin
        match_ok = !format_bad_reg;
        if (two_fields)
        begin
            match_ok = match_ok && (phase_reg == PH_DIGITS_B)
                       && (char_count_reg <= LEN_MAX_TWO);
        end
        else
        begin
            match_ok = match_ok && (phase_reg == PH_DIGITS_A)
                       && (char_count_reg <= LEN_MAX_ONE);
        end
    end

    // Advance the parse state and load the result word
    always_comb
    begin
        char_count_next = char_count_reg;
        phase_next      = phase_reg;
        first_acc_next  = first_acc_reg;
        second_acc_next = second_acc_reg;
        format_bad_next = format_bad_reg;
        out_valid_next  = out_valid_reg && !results.ready;
        out_ok_next     = out_ok_reg;
        out_first_next  = out_first_reg;
        out_second_next = out_second_reg;

        if (accept)
        begin
            if (chars.ch == CH_NUL)
            begin
                out_valid_next  = 1'b1;
                out_ok_next     = match_ok;
                out_first_next  = match_ok ? first_acc_reg : '0;
                out_second_next = (match_ok && two_fields) ? second_acc_reg : '0;
                char_count_next = '0;
                phase_next      = PH_ZERO_A;
                first_acc_next  = '0;
                second_acc_next = '0;
                format_bad_next = 1'b0;
            end
            else
            begin
                if (char_count_reg < COUNT_SAT)
                begin
                    char_count_next = char_count_reg + 1'b1;
                end
                case (phase_reg)
                    PH_ZERO_A, PH_ZERO_B:
                    begin
                        if (chars.ch != CH_ZERO)
                        begin
                            format_bad_next = 1'b1;
                        end
                        phase_next = phase_t'(phase_reg + 3'd1);
                    end
                    PH_X_A, PH_X_B:
                    begin
                        if (chars.ch != CH_X)
                        begin
                            format_bad_next = 1'b1;
                        end
                        phase_next = phase_t'(phase_reg + 3'd1);
                    end
                    PH_DIGITS_A:
                    begin
                        if (two_fields && chars.ch == CH_SLASH)
                        begin
                            phase_next = PH_ZERO_B;
                        end
                        else
                        begin
                            first_acc_next = {first_acc_reg[VALUE_W-NIBBLE_W-1:0], nibble};
                        end
                    end
                    PH_DIGITS_B:
                    begin
                        second_acc_next = {second_acc_reg[VALUE_W-NIBBLE_W-1:0], nibble};
                    end
                    default:
                    begin
                        phase_next      = PH_ZERO_A;
                        format_bad_next = 1'b1;
                    end
                endcase
            end
        end
    end

    // Hold the field count between configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_count_reg <= FIELDS_RESET;
        end
        else if (cfg_wr_en)
        begin
            field_count_reg <= cfg_wr_data;
        end
    end

    // Parse state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_count_reg <= '0;
            phase_reg      <= PH_ZERO_A;
            first_acc_reg  <= '0;
            second_acc_reg <= '0;
            format_bad_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            char_count_reg <= char_count_next;
            phase_reg      <= phase_next;
            first_acc_reg  <= first_acc_next;
            second_acc_reg <= second_acc_next;
            format_bad_reg <= format_bad_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        out_ok_reg     <= out_ok_next;
        out_first_reg  <= out_first_next;
        out_second_reg <= out_second_next;
    end

    assign results.valid        = out_valid_reg;
    assign results.ok           = out_ok_reg;
    assign results.first_value  = out_first_reg;
    assign results.second_value = out_second_reg;

endmodule

FILE: sv/hap_checker.sv
// hap_checker: port-level checks, bound into each hex_argument_parser instance.
// Depends on hap_pkg and assert_macros.svh.
`include "assert_macros.svh"

module hap_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic [hap_pkg::CHAR_W-1:0]  in_ch,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic                        out_ok,
    input logic [hap_pkg::VALUE_W-1:0] out_first,
    input logic [hap_pkg::VALUE_W-1:0] out_second
);
    import hap_pkg::*;

    logic in_term;
    assign in_term = in_valid && in_ready && (in_ch == CH_NUL);

    // A stalled result word holds
    `HAP_ASSERT_NXT(a_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(out_ok) && $stable(out_first) && $stable(out_second),
        "result word changed while stalled")

    // A failed parse reports zero values
    `HAP_ASSERT_IMP(a_zero, clk, rst_n, out_valid && !out_ok,
        out_first == '0 && out_second == '0, "nonzero value with ok low")

    // A terminator gives a result in the next cycle
    `HAP_ASSERT_NXT(a_term, clk, rst_n, in_term, out_valid,
        "no result after terminator")

    // A result shows up only after a terminator
    `HAP_ASSERT_IMP(a_cause, clk, rst_n, $rose(out_valid), $past(in_term),
        "result without terminator")

endmodule

bind hex_argument_parser hap_checker u_hap_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (chars.valid),
    .in_ready   (chars.ready),
    .in_ch      (chars.ch),
    .out_valid  (results.valid),
    .out_ready  (results.ready),
    .out_ok     (results.ok),
    .out_first  (results.first_value),
    .out_second (results.second_value)
);

FILE: bench/hex_argument_parser_tb.sv
// hex_argument_parser_tb: self-checking bench for the streaming hex argument parser.
// Depends on hap_pkg, hap_char_if, hap_result_if and hex_argument_parser.
// Drives character words with random gaps, predicts each parse result, compares on take.
module hex_argument_parser_tb;
    import hap_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Field count codes that the block treats as two-field mode
    localparam logic [CFG_W-1:0] FIELDS_UNUSED_LO = 2'd0;
    localparam logic [CFG_W-1:0] FIELDS_UNUSED_HI = 2'd3;
    localparam int               IDLE_PCT         = 14;
    localparam int               RANDOM_CHARS     = 1800;
    localparam int               SETTLE_CYCLES    = 4;

    typedef struct packed {
        logic               ok;
        logic [VALUE_W-1:0] first_value;
        logic [VALUE_W-1:0] second_value;
    } parse_result_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [CFG_W-1:0]  cfg_wr_data;

    hap_char_if   chars_if ();
    hap_result_if results_if ();

    hex_argument_parser DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .chars       (chars_if),
        .results     (results_if)
    );

    // Predicted parser state
    logic [CFG_W-1:0]   pred_fields;
    logic [COUNT_W-1:0] pred_count;
    phase_t             pred_phase;
    logic [VALUE_W-1:0] pred_first;
    logic [VALUE_W-1:0] pred_second;
    logic               pred_bad;

    parse_result_t pending_results[$];
    logic [CHAR_W-1:0] text_buf[$];

    logic             steady;
    logic [CFG_W-1:0] chosen_fields;
    int               mismatches;
    int               results_checked;
    int               ok_results;
    int               chars_sent;
    int               strings_sent;
    int               cfg_writes;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Generous run limit
    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic logic [NIBBLE_W-1:0] digit_value(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] d;
        d = 8'h00;
        if (c >= "0" && c <= "9")
            d = c - "0";
        else if (c >= "A" && c <= "F")
            d = c - "A" + 8'd10;
        else if (c >= "a" && c <= "f")
            d = c - "a" + 8'd10;
        return d[NIBBLE_W-1:0];
    endfunction

    task automatic clear_parse();
        pred_count  = '0;
        pred_phase  = PH_ZERO_A;
        pred_first  = '0;
        pred_second = '0;
        pred_bad    = 1'b0;
    endtask

    // Advance the predicted parser by one accepted character
    task automatic parse_char(input logic [CHAR_W-1:0] c);
        logic          two;
        parse_result_t res;
        two = (pred_fields != FIELDS_ONE);
        if (c == CH_NUL)
        begin
            res.ok = !pred_bad
                     && (pred_phase == (two ? PH_DIGITS_B : PH_DIGITS_A))
                     && (pred_count <= (two ? LEN_MAX_TWO : LEN_MAX_ONE));
            res.first_value  = res.ok ? pred_first : '0;
            res.second_value = (res.ok && two) ? pred_second : '0;
            pending_results.push_back(res);
            clear_parse();
        end
        else
        begin
            if (pred_count < COUNT_SAT)
                pred_count = pred_count + 1'b1;
            case (pred_phase)
                PH_ZERO_A, PH_ZERO_B:
                begin
                    if (c != CH_ZERO)
                        pred_bad = 1'b1;
                    pred_phase = phase_t'(pred_phase + 3'd1);
                end
                PH_X_A, PH_X_B:
                begin
                    if (c != CH_X)
                        pred_bad = 1'b1;
                    pred_phase = phase_t'(pred_phase + 3'd1);
                end
                PH_DIGITS_A:
                begin
                    if (two && c == CH_SLASH)
                        pred_phase = PH_ZERO_B;
                    else
                        pred_first = {pred_first[VALUE_W-NIBBLE_W-1:0], digit_value(c)};
                end
                PH_DIGITS_B:
                    pred_second = {pred_second[VALUE_W-NIBBLE_W-1:0], digit_value(c)};
                default:
                begin
                    pred_phase = PH_ZERO_A;
                    pred_bad   = 1'b1;
                end
            endcase
        end
    endtask

    // Track register writes and accepted words
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pred_fields = FIELDS_RESET;
            clear_parse();
        end
        else
        begin
            if (cfg_wr_en)
                pred_fields = cfg_wr_data;
            if (chars_if.valid && chars_if.ready)
                parse_char(chars_if.ch);
        end
    end

    // Stall the result side at random
    always @(posedge clk)
    begin
        results_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // Compare each taken result with the oldest prediction
    always @(posedge clk)
    begin
        parse_result_t exp_res;
        if (rst_n && results_if.valid && results_if.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual ok=%0d %h %h", $time,
                         results_if.ok, results_if.first_value, results_if.second_value);
                mismatches++;
            end
            else
            begin
                exp_res = pending_results.pop_front();
                results_checked++;
                if (exp_res.ok)
                    ok_results++;
                if (results_if.ok !== exp_res.ok)
                begin
                    $display("%0t: ok mismatch, expected %0d actual %0d", $time,
                             exp_res.ok, results_if.ok);
                    mismatches++;
                end
                if (results_if.first_value !== exp_res.first_value)
                begin
                    $display("%0t: first_value mismatch, expected %h actual %h", $time,
                             exp_res.first_value, results_if.first_value);
                    mismatches++;
                end
                if (results_if.second_value !== exp_res.second_value)
                begin
                    $display("%0t: second_value mismatch, expected %h actual %h", $time,
                             exp_res.second_value, results_if.second_value);
                    mismatches++;
                end
            end
        end
    end

    // Present one word, with random gaps ahead of it, and hold until taken
    task automatic send_char(input logic [CHAR_W-1:0] c);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            chars_if.valid <= 1'b0;
            @(posedge clk);
        end
        chars_if.valid <= 1'b1;
        chars_if.ch    <= c;
        @(posedge clk);
        while (!chars_if.ready)
            @(posedge clk);
        chars_sent++;
        if (c == CH_NUL)
            strings_sent++;
    endtask

    task automatic send_text(input string s, input bit terminate);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
        if (terminate)
            send_char(CH_NUL);
    endtask

    // Drop valid and hold until every predicted result has been taken
    task automatic settle();
        chars_if.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_fields(input logic [CFG_W-1:0] v);
        settle();
        cfg_wr_en     <= 1'b1;
        cfg_wr_data   <= v;
        chosen_fields  = v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        cfg_writes++;
    endtask

    function automatic logic [CHAR_W-1:0] random_digit();
        int n;
        n = $urandom_range(21);
        if (n < 10)
            return CHAR_W'(CH_ZERO + n);
        else if (n < 16)
            return CHAR_W'("a" + n - 10);
        return CHAR_W'("A" + n - 16);
    endfunction

    task automatic push_field(input int digits);
        text_buf.push_back(CH_ZERO);
        text_buf.push_back(CH_X);
        for (int i = 0; i < digits; i++)
            text_buf.push_back(random_digit());
    endtask

    // Build one random string: mostly well formed, some corrupted, some noise
    task automatic build_string();
        int kind;
        int pos;
        int len;
        text_buf.delete();
        kind = $urandom_range(99);
        if (kind < 85)
        begin
            push_field($urandom_range(10));
            if (chosen_fields != FIELDS_ONE)
            begin
                text_buf.push_back(CH_SLASH);
                push_field($urandom_range(10));
            end
            if (kind >= 70)
            begin
                pos = $urandom_range(text_buf.size() - 1);
                case ($urandom_range(3))
                    0: text_buf[pos] = CHAR_W'($urandom_range(255, 1));
                    1: text_buf[pos] = CH_SLASH;
                    2: text_buf[pos] = "X";
                    default: text_buf.delete(pos);
                endcase
            end
        end
        else
        begin
            len = $urandom_range(24);
            for (int i = 0; i < len; i++)
            begin
                case ($urandom_range(4))
                    0: text_buf.push_back(CH_ZERO);
                    1: text_buf.push_back(CH_X);
                    2: text_buf.push_back(CH_SLASH);
                    default: text_buf.push_back(CHAR_W'($urandom_range(255, 1)));
                endcase
            end
        end
        text_buf.push_back(CH_NUL);
    endtask

    // Two-field forms at the reset setting
    task automatic test_two_field_forms();
        send_text("0x1/0x2", 1);
        send_text("", 1);
        send_text("0xFFFFFFFF/0xffffffff", 1);
        send_text("0x123456789/0x12345678", 1);
        send_text("0X1/0x2", 1);
        send_text("0x12", 1);
        send_text("0x123456789/0xAbC/9", 1);
        send_text("0xg1/0x", 0);
        send_char(8'hFF);
        send_char(8'h80);
        send_char(CH_NUL);
        send_text("1x1/0x1", 1);
    endtask

    task automatic test_one_field_forms();
        set_fields(FIELDS_ONE);
        send_text("0x12345678", 1);
        send_text("0x123456789", 1);
        send_text("0x1/2", 1);
        send_text("0x", 1);
    endtask

    // Switch the field count while a string is half parsed
    task automatic test_mode_switch();
        send_text("0x5", 0);
        set_fields(FIELDS_TWO);
        send_text("/0x6", 1);
        send_text("0x7/0x8", 0);
        set_fields(FIELDS_ONE);
        send_char(CH_NUL);
        set_fields(FIELDS_TWO);
        send_text("0x9", 0);
        set_fields(FIELDS_ONE);
        send_char(CH_NUL);
    endtask

    task automatic test_unused_codes();
        set_fields(FIELDS_UNUSED_LO);
        send_text("0xA/0xB", 1);
        set_fields(FIELDS_UNUSED_HI);
        send_text("0x1/0x2", 1);
        send_text("0x1", 1);
    endtask

    task automatic test_random_strings();
        int start_chars;
        int since_cfg;
        int pick;
        start_chars = chars_sent;
        since_cfg   = 0;
        while (chars_sent - start_chars < RANDOM_CHARS)
        begin
            // hold one long stretch with no gaps on either side
            steady = (chars_sent - start_chars >= 600) && (chars_sent - start_chars < 900);
            if (since_cfg > 30 && $urandom_range(9) == 0)
            begin
                pick = $urandom_range(9);
                if (pick < 4)
                    set_fields(FIELDS_ONE);
                else if (pick < 8)
                    set_fields(FIELDS_TWO);
                else if (pick == 8)
                    set_fields(FIELDS_UNUSED_LO);
                else
                    set_fields(FIELDS_UNUSED_HI);
                since_cfg = 0;
            end
            build_string();
            foreach (text_buf[i])
                send_char(text_buf[i]);
            since_cfg++;
        end
        steady = 1'b0;
    endtask

    initial
    begin
        rst_n            = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_wr_data      = '0;
        chars_if.valid   = 1'b0;
        chars_if.ch      = '0;
        results_if.ready = 1'b0;
        steady           = 1'b0;
        chosen_fields    = FIELDS_RESET;
        mismatches       = 0;
        results_checked  = 0;
        ok_results       = 0;
        chars_sent       = 0;
        strings_sent     = 0;
        cfg_writes       = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_two_field_forms();
        test_one_field_forms();
        test_mode_switch();
        test_unused_codes();
        test_random_strings();

        settle();
        repeat (10) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $display("%0t: %0d results still expected, actual none", $time,
                     pending_results.size());
            mismatches++;
        end
        $display("Sent %0d characters in %0d strings over %0d field count writes.",
                 chars_sent, strings_sent, cfg_writes);
        $display("Checked %0d results, %0d accepted as well formed, %0d mismatches.",
                 results_checked, ok_results, mismatches);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: files.f
+incdir+sv
sv/hap_pkg.sv
sv/hap_char_if.sv
sv/hap_result_if.sv
sv/hex_argument_parser.sv
sv/hap_checker.sv
bench/hex_argument_parser_tb.sv
